>>> rtl/core/strn_pkg.sv
// Shared constants and types for the spin-orbit torque right-hand-side node unit.
package strn_pkg;

  // Magnitude width of every clamped product, and the clamp value itself.
  localparam int MAG_W = 62;
  localparam logic [MAG_W-1:0] MAG_CAP = 62'h3FFF_FFFF_FFFF_FFFF;

  // Width of the saturated 48-bit right-hand side.
  localparam int RHS_W = 48;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_ENABLE   = 3'd0,
    CFG_SCALE    = 3'd1,
    CFG_ENVELOPE = 3'd2,
    CFG_XI_DL    = 3'd3,
    CFG_XI_FL    = 3'd4,
    CFG_SPIN_X   = 3'd5,
    CFG_SPIN_Y   = 3'd6,
    CFG_SPIN_Z   = 3'd7
  } cfg_reg_t;

endpackage

>>> rtl/core/spin_torque_rhs_node_unit.sv
// Top level of the spin-orbit torque right-hand-side node unit.
//
// Each input item is one mesh node: magnetization, saturation magnetization,
// damping, the incoming right-hand side and a node enable. Each item gives
// exactly one result item, the right-hand side with the damping-like and
// field-like torque added and saturated to 48 bits when the node is active.
// Both channels use valid and stall; an item moves at a clock edge with valid
// high and stall low. The configuration port writes one register per cycle
// with cfg_we high, and is to be written only while the pipeline is empty.
// One item is accepted every cycle unless in_stall is high. The depth is set
// by the two pipelined dividers (base rate over the saturation magnetization
// and the reciprocal of one plus damping squared, 16 stages each) and by the
// chain of split multipliers behind them.
// When an output item is stalled, the whole pipeline holds and in_stall rises
// in the same cycle, so nothing is lost or repeated. Reset clears the valid
// bits and loads the register defaults; payload registers are not reset.
module spin_torque_rhs_node_unit #(
  parameter int MAG_FRAC_BITS = 30
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [61:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] mag_x,
  input  logic signed [31:0] mag_y,
  input  logic signed [31:0] mag_z,
  input  logic [23:0]        sat_mag,
  input  logic [16:0]        damping,
  input  logic signed [47:0] rhs_in_x,
  input  logic signed [47:0] rhs_in_y,
  input  logic signed [47:0] rhs_in_z,
  input  logic               node_on,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [47:0] rhs_out_x,
  output logic signed [47:0] rhs_out_y,
  output logic signed [47:0] rhs_out_z
);
  import strn_pkg::*;

  localparam int LAT = 29;

  // Configuration registers.
  logic               torque_enable;
  logic [61:0]        torque_scale;
  logic signed [31:0] envelope_level;
  logic signed [20:0] eff_damping_like;
  logic signed [20:0] eff_field_like;
  logic signed [31:0] spin_dir [3];

  // Pipeline control.
  logic           en;
  logic [LAT:1]   vld;

  function automatic logic signed [63:0] to_s64(input logic neg, input logic [62:0] mag);
    logic signed [63:0] v;
    v = $signed({1'b0, mag});
    return neg ? -v : v;
  endfunction

  // Sign in bit 63, magnitude below it.
  function automatic logic [63:0] abs_sm(input logic signed [63:0] v);
    logic [63:0] m;
    m = v[63] ? 64'(-v) : 64'(v);
    return {v[63], m[62:0]};
  endfunction

  // Register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      torque_enable    <= 1'b0;
      torque_scale     <= '0;
      envelope_level   <= 32'sh2000_0000;
      eff_damping_like <= '0;
      eff_field_like   <= '0;
      spin_dir[0]      <= '0;
      spin_dir[1]      <= '0;
      spin_dir[2]      <= 32'sh4000_0000;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_ENABLE:   torque_enable    <= cfg_data[0];
        CFG_SCALE:    torque_scale     <= cfg_data;
        CFG_ENVELOPE: envelope_level   <= cfg_data[31:0];
        CFG_XI_DL:    eff_damping_like <= cfg_data[20:0];
        CFG_XI_FL:    eff_field_like   <= cfg_data[20:0];
        CFG_SPIN_X:   spin_dir[0]      <= cfg_data[31:0];
        CFG_SPIN_Y:   spin_dir[1]      <= cfg_data[31:0];
        CFG_SPIN_Z:   spin_dir[2]      <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  // The whole pipeline advances unless a finished item is held at the output.
  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-1:1], in_valid};
    end
  end

  assign out_valid = vld[LAT];

  // Sign and magnitude of the register operands.
  logic [31:0] env_mag;
  logic [20:0] xdl_mag;
  logic [20:0] xfl_mag;
  logic [31:0] sd_mag [3];
  logic        sd_neg [3];

  assign env_mag = envelope_level[31] ? 32'(-envelope_level) : 32'(envelope_level);
  assign xdl_mag = eff_damping_like[20] ? 21'(-eff_damping_like) : 21'(eff_damping_like);
  assign xfl_mag = eff_field_like[20] ? 21'(-eff_field_like) : 21'(eff_field_like);

  // Sign and magnitude of the magnetization.
  logic signed [31:0] m_in [3];
  logic [31:0]        m_mag [3];
  logic               m_neg [3];

  assign m_in[0] = mag_x;
  assign m_in[1] = mag_y;
  assign m_in[2] = mag_z;

  for (genvar k = 0; k < 3; k++) begin : g_abs
    assign sd_neg[k] = spin_dir[k][31];
    assign sd_mag[k] = spin_dir[k][31] ? 32'(-spin_dir[k]) : 32'(spin_dir[k]);
    assign m_neg[k]  = m_in[k][31];
    assign m_mag[k]  = m_in[k][31] ? 32'(-m_in[k]) : 32'(m_in[k]);
  end

  // Node takes the torque only when everything is enabled and Ms is nonzero.
  logic act_in;
  assign act_in = torque_enable && node_on && (sat_mag != 24'd0);

  // ---------------- Base rate: scale * |env| / (Ms * 2^13) ----------------

  logic [62:0] pl_s1;
  logic [62:0] ph_s1;
  logic [23:0] sat_s1;
  logic [23:0] sat_s2;
  logic [34:0] den_s1;
  logic [34:0] den_s2;
  logic [93:0] prod_full;
  logic        ovf_s2;
  logic [16:0] rem0_s2;
  logic [63:0] num_s2;

  // Split scale product and the damping denominator.
  always_ff @(posedge clk) begin
    if (en) begin
      pl_s1  <= 63'(torque_scale[30:0]) * 63'(env_mag);
      ph_s1  <= 63'(torque_scale[61:31]) * 63'(env_mag);
      sat_s1 <= sat_mag;
      den_s1 <= (35'd1 << 32) + 35'(34'(damping) * 34'(damping));
    end
  end

  // Full product; quotient overflow shows when the top bits reach Ms.
  assign prod_full = 94'(pl_s1) + (94'(ph_s1) << 31);

  always_ff @(posedge clk) begin
    if (en) begin
      ovf_s2  <= {5'd0, prod_full[93:75]} >= sat_s1;
      rem0_s2 <= prod_full[93:77];
      num_s2  <= prod_full[76:13];
      sat_s2  <= sat_s1;
      den_s2  <= den_s1;
    end
  end

  logic [63:0] qb_s18;
  logic [31:0] inv_s18;
  logic        ovf_s18;

  strn_div #(.N(64), .DW(24), .STEP(4)) u_div_base (
    .clk    (clk),
    .en     (en),
    .rem_in ({7'd0, rem0_s2}),
    .num_in (num_s2),
    .den_in (sat_s2),
    .quot   (qb_s18)
  );

  // Reciprocal of 1 + alpha^2 in Q.30: 2^62 / (2^32 + alpha^2).
  strn_div #(.N(32), .DW(35), .STEP(2)) u_div_inv (
    .clk    (clk),
    .en     (en),
    .rem_in (35'd1 << 30),
    .num_in (32'd0),
    .den_in (den_s2),
    .quot   (inv_s18)
  );

  strn_dly #(.W(1), .DEPTH(16)) u_ovf_dly (
    .clk (clk), .en (en), .d (ovf_s2), .q (ovf_s18)
  );

  logic [MAG_W-1:0] bmag;
  assign bmag = (ovf_s18 || (qb_s18 > 64'(MAG_CAP))) ? MAG_CAP : qb_s18[MAG_W-1:0];

  // ---------------- Damping-like and field-like rates ----------------

  logic             wdl_neg, wfl_neg;
  logic [MAG_W-1:0] wdl_mag, wfl_mag;

  strn_mul #(.AW(MAG_W), .BW(21), .SH(16)) u_mul_wdl (
    .clk (clk), .en (en),
    .a_neg (envelope_level[31]), .a_mag (bmag),
    .b_neg (eff_damping_like[20]), .b_mag (xdl_mag),
    .p_neg (wdl_neg), .p_mag (wdl_mag)
  );

  strn_mul #(.AW(MAG_W), .BW(21), .SH(16)) u_mul_wfl (
    .clk (clk), .en (en),
    .a_neg (envelope_level[31]), .a_mag (bmag),
    .b_neg (eff_field_like[20]), .b_mag (xfl_mag),
    .p_neg (wfl_neg), .p_mag (wfl_mag)
  );

  logic [16:0] alpha_s20;

  strn_dly #(.W(17), .DEPTH(20)) u_alpha_dly (
    .clk (clk), .en (en), .d (damping), .q (alpha_s20)
  );

  logic             awf_neg, awd_neg;
  logic [MAG_W-1:0] awf_mag, awd_mag;

  strn_mul #(.AW(17), .BW(MAG_W), .SH(16)) u_mul_awf (
    .clk (clk), .en (en),
    .a_neg (1'b0), .a_mag (alpha_s20),
    .b_neg (wfl_neg), .b_mag (wfl_mag),
    .p_neg (awf_neg), .p_mag (awf_mag)
  );

  strn_mul #(.AW(17), .BW(MAG_W), .SH(16)) u_mul_awd (
    .clk (clk), .en (en),
    .a_neg (1'b0), .a_mag (alpha_s20),
    .b_neg (wdl_neg), .b_mag (wdl_mag),
    .p_neg (awd_neg), .p_mag (awd_mag)
  );

  logic [125:0] w_s22;

  strn_dly #(.W(126), .DEPTH(2)) u_w_dly (
    .clk (clk), .en (en),
    .d ({wdl_neg, wdl_mag, wfl_neg, wfl_mag}),
    .q (w_s22)
  );

  // Combine the rates; both results keep sign and magnitude.
  logic [63:0] dlp_s23;
  logic [63:0] flp_s23;

  always_ff @(posedge clk) begin
    if (en) begin
      dlp_s23 <= abs_sm(to_s64(w_s22[125], {1'b0, w_s22[124:63]})
                        - to_s64(awf_neg, {1'b0, awf_mag}));
      flp_s23 <= abs_sm(to_s64(w_s22[62], {1'b0, w_s22[61:0]})
                        + to_s64(awd_neg, {1'b0, awd_mag}));
    end
  end

  logic [31:0] inv_s23;

  strn_dly #(.W(32), .DEPTH(5)) u_inv_dly (
    .clk (clk), .en (en), .d (inv_s18), .q (inv_s23)
  );

  logic             dl_neg, fl_neg;
  logic [MAG_W-1:0] dl_mag, fl_mag;

  strn_mul #(.AW(63), .BW(32), .SH(30)) u_mul_dl (
    .clk (clk), .en (en),
    .a_neg (dlp_s23[63]), .a_mag (dlp_s23[62:0]),
    .b_neg (1'b0), .b_mag (inv_s23),
    .p_neg (dl_neg), .p_mag (dl_mag)
  );

  strn_mul #(.AW(63), .BW(32), .SH(30)) u_mul_fl (
    .clk (clk), .en (en),
    .a_neg (flp_s23[63]), .a_mag (flp_s23[62:0]),
    .b_neg (1'b0), .b_mag (inv_s23),
    .p_neg (fl_neg), .p_mag (fl_mag)
  );

  // ---------------- Cross products and torque terms ----------------

  logic             cp_neg [3], cn_neg [3], dp_neg [3], dn_neg [3];
  logic [MAG_W-1:0] cp_mag [3], cn_mag [3], dp_mag [3], dn_mag [3];
  logic             tp_neg [3], tn_neg [3];
  logic [MAG_W-1:0] tp_mag [3], tn_mag [3];
  logic [32:0]      md_s3 [3];
  logic [63:0]      c_s3 [3];
  logic [63:0]      d_s6 [3];
  logic [63:0]      c_s25 [3];
  logic [63:0]      d_s25 [3];
  logic signed [63:0] term_s28 [3];

  for (genvar k = 0; k < 3; k++) begin : g_vec
    localparam int I1 = (k + 1) % 3;
    localparam int I2 = (k + 2) % 3;

    // c = m x sigma.
    strn_mul #(.AW(32), .BW(32), .SH(MAG_FRAC_BITS)) u_mul_cp (
      .clk (clk), .en (en),
      .a_neg (m_neg[I1]), .a_mag (m_mag[I1]),
      .b_neg (sd_neg[I2]), .b_mag (sd_mag[I2]),
      .p_neg (cp_neg[k]), .p_mag (cp_mag[k])
    );

    strn_mul #(.AW(32), .BW(32), .SH(MAG_FRAC_BITS)) u_mul_cn (
      .clk (clk), .en (en),
      .a_neg (m_neg[I2]), .a_mag (m_mag[I2]),
      .b_neg (sd_neg[I1]), .b_mag (sd_mag[I1]),
      .p_neg (cn_neg[k]), .p_mag (cn_mag[k])
    );

    always_ff @(posedge clk) begin
      if (en) begin
        c_s3[k] <= abs_sm(to_s64(cp_neg[k], {1'b0, cp_mag[k]})
                          - to_s64(cn_neg[k], {1'b0, cn_mag[k]}));
      end
    end

    strn_dly #(.W(33), .DEPTH(3)) u_m_dly (
      .clk (clk), .en (en), .d ({m_neg[k], m_mag[k]}), .q (md_s3[k])
    );
  end

  for (genvar k = 0; k < 3; k++) begin : g_dvec
    localparam int I1 = (k + 1) % 3;
    localparam int I2 = (k + 2) % 3;

    // d = m x c.
    strn_mul #(.AW(32), .BW(63), .SH(MAG_FRAC_BITS)) u_mul_dp (
      .clk (clk), .en (en),
      .a_neg (md_s3[I1][32]), .a_mag (md_s3[I1][31:0]),
      .b_neg (c_s3[I2][63]), .b_mag (c_s3[I2][62:0]),
      .p_neg (dp_neg[k]), .p_mag (dp_mag[k])
    );

    strn_mul #(.AW(32), .BW(63), .SH(MAG_FRAC_BITS)) u_mul_dn (
      .clk (clk), .en (en),
      .a_neg (md_s3[I2][32]), .a_mag (md_s3[I2][31:0]),
      .b_neg (c_s3[I1][63]), .b_mag (c_s3[I1][62:0]),
      .p_neg (dn_neg[k]), .p_mag (dn_mag[k])
    );

    always_ff @(posedge clk) begin
      if (en) begin
        d_s6[k] <= abs_sm(to_s64(dp_neg[k], {1'b0, dp_mag[k]})
                          - to_s64(dn_neg[k], {1'b0, dn_mag[k]}));
      end
    end

    strn_dly #(.W(64), .DEPTH(22)) u_c_dly (
      .clk (clk), .en (en), .d (c_s3[k]), .q (c_s25[k])
    );

    strn_dly #(.W(64), .DEPTH(19)) u_d_dly (
      .clk (clk), .en (en), .d (d_s6[k]), .q (d_s25[k])
    );

    // term = fl * c - dl * d.
    strn_mul #(.AW(MAG_W), .BW(63), .SH(MAG_FRAC_BITS)) u_mul_tp (
      .clk (clk), .en (en),
      .a_neg (fl_neg), .a_mag (fl_mag),
      .b_neg (c_s25[k][63]), .b_mag (c_s25[k][62:0]),
      .p_neg (tp_neg[k]), .p_mag (tp_mag[k])
    );

    strn_mul #(.AW(MAG_W), .BW(63), .SH(MAG_FRAC_BITS)) u_mul_tn (
      .clk (clk), .en (en),
      .a_neg (dl_neg), .a_mag (dl_mag),
      .b_neg (d_s25[k][63]), .b_mag (d_s25[k][62:0]),
      .p_neg (tn_neg[k]), .p_mag (tn_mag[k])
    );

    always_ff @(posedge clk) begin
      if (en) begin
        term_s28[k] <= to_s64(tp_neg[k], {1'b0, tp_mag[k]})
                     - to_s64(tn_neg[k], {1'b0, tn_mag[k]});
      end
    end
  end

  // ---------------- Right-hand-side update ----------------

  logic [144:0]       side_s28;
  logic signed [47:0] rhs_s28 [3];
  logic               act_s28;
  logic signed [47:0] out_q [3];

  strn_dly #(.W(145), .DEPTH(28)) u_rhs_dly (
    .clk (clk), .en (en),
    .d ({act_in, rhs_in_z, rhs_in_y, rhs_in_x}),
    .q (side_s28)
  );

  assign act_s28    = side_s28[144];
  assign rhs_s28[0] = side_s28[47:0];
  assign rhs_s28[1] = side_s28[95:48];
  assign rhs_s28[2] = side_s28[143:96];

  for (genvar k = 0; k < 3; k++) begin : g_out
    logic [63:0]        tabs;
    logic [46:0]        tsh;
    logic signed [49:0] tval;
    logic signed [49:0] tsum;

    // Truncate the term toward zero to integer rad/s, add and saturate.
    assign tabs = term_s28[k][63] ? 64'(-term_s28[k]) : 64'(term_s28[k]);
    assign tsh  = tabs[62:16];
    assign tval = term_s28[k][63] ? -$signed({3'd0, tsh}) : $signed({3'd0, tsh});
    assign tsum = {{2{rhs_s28[k][47]}}, rhs_s28[k]} + tval;

    always_ff @(posedge clk) begin
      if (en) begin
        if (!act_s28) begin
          out_q[k] <= rhs_s28[k];
        end else if (tsum > 50'sh0_7FFF_FFFF_FFFF) begin
          out_q[k] <= 48'sh7FFF_FFFF_FFFF;
        end else if (tsum < -50'sh0_8000_0000_0000) begin
          out_q[k] <= 48'sh8000_0000_0000;
        end else begin
          out_q[k] <= tsum[RHS_W-1:0];
        end
      end
    end
  end

  assign rhs_out_x = out_q[0];
  assign rhs_out_y = out_q[1];
  assign rhs_out_z = out_q[2];

  // ---------------- Assertions ----------------

  // A held output freezes every stage of the pipeline.
  a_stall_freeze: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> $stable(vld))
    else $error("pipeline moved while the output was stalled");

  // An item in the stage before the output reaches the output on the next advance.
  a_last_stage: assert property (@(posedge clk) disable iff (rst)
    (en && vld[LAT-1]) |=> out_valid)
    else $error("item lost between the last stage and the output");

  // Nodes without torque leave the x component of the right-hand side untouched.
  a_pass: assert property (@(posedge clk) disable iff (rst)
    (en && vld[LAT-1] && !act_s28) |=> (rhs_out_x == $past(rhs_s28[0])))
    else $error("pass-through node changed its right-hand side");

  // The reciprocal of 1 + alpha^2 never exceeds one in Q.30.
  a_inv_range: assert property (@(posedge clk) disable iff (rst)
    vld[18] |-> (inv_s18 <= 32'h4000_0000))
    else $error("damping reciprocal out of range");

endmodule

>>> rtl/core/strn_dly.sv
// Enabled shift register that keeps side data aligned with the pipeline.
module strn_dly #(
  parameter int W     = 8,
  parameter int DEPTH = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] pipe [DEPTH];

  // Every tap moves one place when the pipeline advances.
  always_ff @(posedge clk) begin
    if (en) begin
      pipe[0] <= d;
      for (int i = 1; i < DEPTH; i++) begin
        pipe[i] <= pipe[i-1];
      end
    end
  end

  assign q = pipe[DEPTH-1];

endmodule

>>> rtl/core/strn_mul.sv
// Two-stage sign-magnitude multiplier with right shift and magnitude clamp.
module strn_mul #(
  parameter int AW = 32,
  parameter int BW = 32,
  parameter int SH = 16
) (
  input  logic                       clk,
  input  logic                       en,
  input  logic                       a_neg,
  input  logic [AW-1:0]              a_mag,
  input  logic                       b_neg,
  input  logic [BW-1:0]              b_mag,
  output logic                       p_neg,
  output logic [strn_pkg::MAG_W-1:0] p_mag
);
  import strn_pkg::*;

  localparam int AL = (AW + 1) / 2;
  localparam int AH = AW - AL;
  localparam int BL = (BW + 1) / 2;
  localparam int BH = BW - BL;
  localparam int PW = AW + BW;

  logic [AL+BL-1:0] pp_ll;
  logic [AL+BH-1:0] pp_lh;
  logic [AH+BL-1:0] pp_hl;
  logic [AH+BH-1:0] pp_hh;
  logic             neg1;
  logic [PW-1:0]    sum;
  logic [PW-1:0]    shd;

  // First stage: four half-width partial products.
  always_ff @(posedge clk) begin
    if (en) begin
      pp_ll <= a_mag[AL-1:0] * b_mag[BL-1:0];
      pp_lh <= a_mag[AL-1:0] * b_mag[BW-1:BL];
      pp_hl <= a_mag[AW-1:AL] * b_mag[BL-1:0];
      pp_hh <= a_mag[AW-1:AL] * b_mag[BW-1:BL];
      neg1  <= a_neg ^ b_neg;
    end
  end

  // Second stage: combine, truncate toward zero and clamp the magnitude.
  assign sum = PW'(pp_ll) + (PW'(pp_lh) << BL) + (PW'(pp_hl) << AL)
             + (PW'(pp_hh) << (AL + BL));
  assign shd = sum >> SH;

  always_ff @(posedge clk) begin
    if (en) begin
      p_neg <= neg1;
      p_mag <= (shd > PW'(MAG_CAP)) ? MAG_CAP : shd[MAG_W-1:0];
    end
  end

endmodule

>>> rtl/core/strn_div.sv
// Pipelined restoring divider, a fixed number of quotient bits per stage.
module strn_div #(
  parameter int N    = 64,
  parameter int DW   = 24,
  parameter int STEP = 4
) (
  input  logic          clk,
  input  logic          en,
  input  logic [DW-1:0] rem_in,
  input  logic [N-1:0]  num_in,
  input  logic [DW-1:0] den_in,
  output logic [N-1:0]  quot
);

  localparam int NST = N / STEP;

  logic [DW-1:0] rem_q [NST];
  logic [N-1:0]  acc_q [NST];
  logic [DW-1:0] den_q [NST];

  // Dividend bits leave the top of acc while quotient bits enter at the bottom.
  function automatic logic [DW+N-1:0] div_steps(input logic [DW-1:0] r,
                                                input logic [N-1:0]  a,
                                                input logic [DW-1:0] dv);
    logic [DW:0]   t;
    logic [DW-1:0] rr;
    logic [N-1:0]  aa;
    rr = r;
    aa = a;
    for (int j = 0; j < STEP; j++) begin
      t  = {rr, aa[N-1]};
      aa = {aa[N-2:0], 1'b0};
      if (t >= {1'b0, dv}) begin
        t     = t - {1'b0, dv};
        aa[0] = 1'b1;
      end
      rr = t[DW-1:0];
    end
    return {rr, aa};
  endfunction

  for (genvar s = 0; s < NST; s++) begin : g_st
    logic [DW-1:0]   r_in;
    logic [DW-1:0]   d_in;
    logic [N-1:0]    a_in;
    logic [DW+N-1:0] nx;

    if (s == 0) begin : g_first
      assign r_in = rem_in;
      assign a_in = num_in;
      assign d_in = den_in;
    end else begin : g_rest
      assign r_in = rem_q[s-1];
      assign a_in = acc_q[s-1];
      assign d_in = den_q[s-1];
    end

    assign nx = div_steps(r_in, a_in, d_in);

    // Stage register for partial remainder, quotient and divisor.
    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[s] <= nx[DW+N-1:N];
        acc_q[s] <= nx[N-1:0];
        den_q[s] <= d_in;
      end
    end
  end

  assign quot = acc_q[NST-1];

endmodule
